/* rtl/brf_pkg.sv */
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Shared constants, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int MaxDepthDef = 4096;
  localparam int LanesDef    = 8;

  // Field widths fixed by the interface.
  localparam int CountW   = 4;
  localparam int SizeLogW = 4;

  localparam logic [SizeLogW-1:0] SizeLog2Rst = SizeLogW'(12);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BUSY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP
  } state_e;

endpackage

/* rtl/byte_ring_fifo_block_transfer_core.sv */
// ----------------------------------------------------------------------------
// Byte ring FIFO with block transfers
// Power-of-two ring of bytes in one synchronous RAM, filled and drained in
// runs of up to LANES bytes per command.
// ----------------------------------------------------------------------------
// Pulse start_i while busy_o is low to issue a push or pop of byte_count_i
// bytes. The ring RAM has a single port and moves one byte per cycle; a pop
// also waits for the registered RAM read data, and a rejected or empty command
// finishes without leaving idle. The result beat appears on done_o for exactly
// one cycle and cannot be stalled, so the receiver must capture it when it
// shows.
// Writing the size register empties the FIFO; write it only while idle.
// ----------------------------------------------------------------------------
module byte_ring_fifo_block_transfer_core #(
  parameter int MAX_DEPTH = brf_pkg::MaxDepthDef,
  parameter int LANES     = brf_pkg::LanesDef,
  localparam int PW       = $clog2(MAX_DEPTH + 1),
  localparam int DW       = 8 * LANES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brf_pkg::SizeLogW-1:0] cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cmd_i,
  input  logic [brf_pkg::CountW-1:0]   byte_count_i,
  input  logic [DW-1:0]                push_data_i,
  output logic                         done_o,
  output logic                         status_o,
  output logic [DW-1:0]                pop_data_o,
  output logic [PW-1:0]                fill_level_o
);

  localparam int AW     = $clog2(MAX_DEPTH);
  localparam int MaxLog = PW - 1;
  localparam int SEW    = $clog2(PW);
  localparam int CW     = $clog2(LANES + 1);

  logic [7:0] ring_mem [MAX_DEPTH];
  logic [7:0] rdata_q;
  logic       mem_we;

  brf_pkg::state_e state_q, state_d;

  logic [brf_pkg::SizeLogW-1:0] size_q;
  logic [PW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]  cnt_q, cnt_d, k_q, k_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic [DW-1:0]  data_q, data_d, acc_q, acc_d;
  logic [LANES-1:0] lane_q, lane_d;
  logic           done_q, done_d, status_q, status_d;
  logic [DW-1:0]  pop_q, pop_d;
  logic [PW-1:0]  fill_q, fill_d;

  logic [SEW-1:0] s_eff;
  logic [PW-1:0]  size_w, pmask, imask, fill_now, free_now;

  // Ring size in use, clamped to the legal range for this memory.
  always_comb begin
    if (int'(size_q) > MaxLog) begin
      s_eff = SEW'(MaxLog);
    end else if (size_q == '0) begin
      s_eff = SEW'(1);
    end else begin
      s_eff = SEW'(size_q);
    end
    size_w   = PW'(1) << s_eff;
    // At the largest size the doubled value wraps to zero, so the mask is all ones.
    pmask    = (size_w << 1) - PW'(1);
    imask    = size_w - PW'(1);
    fill_now = (wp_q - rp_q) & pmask;
    free_now = size_w - fill_now;
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    addr_d   = addr_q;
    data_d   = data_q;
    acc_d    = acc_q;
    lane_d   = lane_q;
    done_d   = 1'b0;
    status_d = status_q;
    pop_d    = pop_q;
    fill_d   = fill_q;
    mem_we   = 1'b0;

    case (state_q)
      brf_pkg::ST_IDLE: begin
        if (start_i) begin
          cnt_d  = CW'(byte_count_i);
          k_d    = '0;
          data_d = push_data_i;
          acc_d  = '0;
          lane_d = LANES'(1);
          pop_d  = '0;
          fill_d = fill_now;
          if (int'(byte_count_i) > LANES) begin
            done_d   = 1'b1;
            status_d = brf_pkg::STATUS_BUSY;
          end else if (byte_count_i == '0) begin
            done_d   = 1'b1;
            status_d = brf_pkg::STATUS_OK;
          end else if (cmd_i == brf_pkg::CMD_PUSH) begin
            if (int'(byte_count_i) > int'(free_now)) begin
              done_d   = 1'b1;
              status_d = brf_pkg::STATUS_BUSY;
            end else begin
              addr_d  = AW'(wp_q & imask);
              state_d = brf_pkg::ST_PUSH;
            end
          end else begin
            if (int'(byte_count_i) > int'(fill_now)) begin
              done_d   = 1'b1;
              status_d = brf_pkg::STATUS_BUSY;
            end else begin
              addr_d  = AW'(rp_q & imask);
              state_d = brf_pkg::ST_POP;
            end
          end
        end
      end

      brf_pkg::ST_PUSH: begin
        mem_we = 1'b1;
        data_d = data_q >> 8;
        addr_d = AW'((PW'(addr_q) + PW'(1)) & imask);
        k_d    = k_q + CW'(1);
        if (k_d == cnt_q) begin
          wp_d     = (wp_q + PW'(cnt_q)) & pmask;
          fill_d   = (wp_d - rp_q) & pmask;
          done_d   = 1'b1;
          status_d = brf_pkg::STATUS_OK;
          state_d  = brf_pkg::ST_IDLE;
        end
      end

      brf_pkg::ST_POP: begin
        // Reads go out while k is below the count; each one lands in the next cycle.
        if (k_q != cnt_q) begin
          addr_d = AW'((PW'(addr_q) + PW'(1)) & imask);
        end
        if (k_q != '0) begin
          for (int i = 0; i < LANES; i++) begin
            if (lane_q[i]) begin
              acc_d[8*i +: 8] = rdata_q;
            end
          end
          lane_d = lane_q << 1;
        end
        k_d = k_q + CW'(1);
        if (k_q == cnt_q) begin
          rp_d     = (rp_q + PW'(cnt_q)) & pmask;
          fill_d   = (wp_q - rp_d) & pmask;
          pop_d    = acc_d;
          done_d   = 1'b1;
          status_d = brf_pkg::STATUS_OK;
          state_d  = brf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = brf_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      wp_d = '0;
      rp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brf_pkg::ST_IDLE;
      size_q  <= brf_pkg::SizeLog2Rst;
      wp_q    <= '0;
      rp_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    addr_q   <= addr_d;
    data_q   <= data_d;
    acc_q    <= acc_d;
    lane_q   <= lane_d;
    status_q <= status_d;
    pop_q    <= pop_d;
    fill_q   <= fill_d;
  end

  // Single-port ring RAM with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[addr_q] <= data_q[7:0];
    end
    rdata_q <= ring_mem[addr_q];
  end

  assign busy_o       = (state_q != brf_pkg::ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign pop_data_o   = pop_q;
  assign fill_level_o = fill_q;

endmodule
